[rtl/weekly_zone_schedule_matcher_defines.svh]
// Assertion macros used by the checker file.
`ifndef WEEKLY_ZONE_SCHEDULE_MATCHER_DEFINES_SVH
`define WEEKLY_ZONE_SCHEDULE_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WZSM_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define WZSM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/wzsm_pkg.sv]
`timescale 1ns / 1ps

package wzsm_pkg;

	localparam logic [1:0] MODE_RUN   = 2'd0;
	localparam logic [1:0] MODE_PROG  = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	localparam logic [1:0] WEEKS_FIRST  = 2'd0;
	localparam logic [1:0] WEEKS_SECOND = 2'd1;
	localparam logic [1:0] WEEKS_BOTH   = 2'd2;

	localparam logic [19:0] DAY_SECONDS = 20'd86400;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_JOB,
		ST_RUN,
		ST_MASK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [2:0]  day;
		logic [16:0] start;
		logic [1:0]  weeks;
	} run_entry_t;

	typedef struct packed {
		logic [3:0]  station;
		logic [15:0] delay;
		logic [15:0] length;
	} prog_entry_t;

	function automatic logic [19:0] week_seconds(input logic [16:0] tod, input logic [2:0] day);
		logic [19:0] base;
		base = 20'(day) * DAY_SECONDS;
		return base + 20'(tod);
	endfunction

endpackage

[rtl/weekly_zone_schedule_matcher.sv]
`timescale 1ns / 1ps

// Weekly zone schedule matcher. Load items (mode 0 run slot, mode 1 station
// program) are taken while the matcher is idle; loads to a slot beyond the
// table are dropped. A query (mode 2) walks the tables held in two single-port
// memories, one entry per cycle: a pass over the programs for the job length,
// a pass over the runs until the first one whose window holds the current week
// time, and, if one does, a second pass over the programs for the station mask.
// While the result register is free, a query holds the input stalled until its
// result is loaded, less long when an early run matches or none does; a result
// still held downstream keeps the final load waiting longer. The result sits in
// an output register, so loads and the next query are taken while it waits.
// Both tables read as invalid right after reset.
module weekly_zone_schedule_matcher #(
	parameter int RUN_SLOTS     = 8,
	parameter int PROGRAM_SLOTS = 8,
	parameter int STATIONS      = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [2:0]  entry_index,
	input  logic        entry_valid,
	input  logic [2:0]  run_day,
	input  logic [16:0] run_time,
	input  logic [1:0]  run_weeks,
	input  logic [3:0]  station_number,
	input  logic [15:0] start_delay,
	input  logic [15:0] open_length,
	input  logic [16:0] now_time,
	input  logic [2:0]  now_day,
	input  logic        week_one,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        run_active,
	output logic [2:0]  run_slot,
	output logic [15:0] station_mask,
	output logic [15:0] job_length
);

	localparam int RAW  = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
	localparam int PAW  = (PROGRAM_SLOTS > 1) ? $clog2(PROGRAM_SLOTS) : 1;
	localparam int MAXN = (RUN_SLOTS > PROGRAM_SLOTS) ? RUN_SLOTS : PROGRAM_SLOTS;
	localparam int CW   = $clog2(MAXN + 1);

	localparam logic [CW-1:0] RUN_N  = CW'(RUN_SLOTS);
	localparam logic [CW-1:0] PROG_N = CW'(PROGRAM_SLOTS);
	localparam logic [6:0]    RUN_L  = 7'(RUN_SLOTS);
	localparam logic [6:0]    PROG_L = 7'(PROGRAM_SLOTS);
	localparam logic [5:0]    STAT_L = 6'(STATIONS);

	wzsm_pkg::run_entry_t  run_mem [RUN_SLOTS];
	wzsm_pkg::prog_entry_t prog_mem [PROGRAM_SLOTS];

	logic [RUN_SLOTS-1:0]     run_vld_q;
	logic [PROGRAM_SLOTS-1:0] prog_vld_q;

	wzsm_pkg::state_t state_q, state_d;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_s1;
	logic          rd_vld_s1;
	logic          run_v_s1;
	logic          prog_v_s1;
	wzsm_pkg::run_entry_t  run_rd_s1;
	wzsm_pkg::prog_entry_t prog_rd_s1;

	logic [19:0]         week_time_q;
	logic [1:0]          want_q;
	logic [15:0]         len_q;
	logic [15:0]         since_q;
	logic                active_q;
	logic [RAW-1:0]      slot_q;
	logic [STATIONS-1:0] mask_q;

	logic        accept;
	logic        run_we, prog_we, query_go;
	logic        issue, run_re, prog_re;
	logic [CW-1:0] scan_n;
	logic        last, hit, fin_load;
	logic [20:0] diff;
	logic [16:0] sum17;
	logic        week_ok;

	assign accept   = in_valid && !in_stall;
	assign run_we   = accept && (mode == wzsm_pkg::MODE_RUN) && ({4'b0, entry_index} < RUN_L);
	assign prog_we  = accept && (mode == wzsm_pkg::MODE_PROG) && ({4'b0, entry_index} < PROG_L);
	assign query_go = accept && (mode == wzsm_pkg::MODE_QUERY);

	assign sum17   = {1'b0, prog_rd_s1.delay} + {1'b0, prog_rd_s1.length};
	assign diff    = {1'b0, week_time_q} - {1'b0, wzsm_pkg::week_seconds(run_rd_s1.start,
		run_rd_s1.day)};
	assign week_ok = (run_rd_s1.weeks == want_q) || (run_rd_s1.weeks == wzsm_pkg::WEEKS_BOTH);
	assign hit     = (state_q == wzsm_pkg::ST_RUN) && rd_vld_s1 && run_v_s1 && week_ok &&
		!diff[20] && (diff[19:0] < {4'b0, len_q});
	assign scan_n  = (state_q == wzsm_pkg::ST_RUN) ? RUN_N : PROG_N;
	assign last    = rd_vld_s1 && (idx_s1 == scan_n - CW'(1));

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		issue    = 1'b0;
		fin_load = 1'b0;
		unique case (state_q)
			wzsm_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && (mode == wzsm_pkg::MODE_QUERY)) begin
					state_d = wzsm_pkg::ST_JOB;
				end
			end
			wzsm_pkg::ST_JOB: begin
				issue = (cnt_q < PROG_N) && !last;
				if (last) begin
					state_d = wzsm_pkg::ST_RUN;
				end
			end
			wzsm_pkg::ST_RUN: begin
				issue = (cnt_q < RUN_N) && !last && !hit;
				if (hit) begin
					state_d = wzsm_pkg::ST_MASK;
				end else if (last) begin
					state_d = wzsm_pkg::ST_FIN;
				end
			end
			wzsm_pkg::ST_MASK: begin
				issue = (cnt_q < PROG_N) && !last;
				if (last) begin
					state_d = wzsm_pkg::ST_FIN;
				end
			end
			wzsm_pkg::ST_FIN: begin
				if (!out_valid || !out_stall) begin
					fin_load = 1'b1;
					state_d  = wzsm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wzsm_pkg::ST_IDLE;
			end
		endcase
		run_re  = issue && (state_q == wzsm_pkg::ST_RUN);
		prog_re = issue && (state_q != wzsm_pkg::ST_RUN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wzsm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_vld_q  <= '0;
			prog_vld_q <= '0;
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (run_we) begin
				run_vld_q[RAW'(entry_index)] <= entry_valid;
			end
			if (prog_we) begin
				prog_vld_q[PAW'(entry_index)] <= entry_valid;
			end
			rd_vld_s1 <= issue;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (fin_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_we) begin
			run_mem[RAW'(entry_index)] <= '{day: run_day, start: run_time, weeks: run_weeks};
		end
		if (run_re) begin
			run_rd_s1 <= run_mem[cnt_q[RAW-1:0]];
			run_v_s1  <= run_vld_q[cnt_q[RAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (prog_we) begin
			prog_mem[PAW'(entry_index)] <= '{station: station_number, delay: start_delay,
				length: open_length};
		end
		if (prog_re) begin
			prog_rd_s1 <= prog_mem[cnt_q[PAW-1:0]];
			prog_v_s1  <= prog_vld_q[cnt_q[PAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (query_go) begin
			week_time_q <= wzsm_pkg::week_seconds(now_time, now_day);
			want_q      <= week_one ? wzsm_pkg::WEEKS_FIRST : wzsm_pkg::WEEKS_SECOND;
			len_q       <= '0;
			mask_q      <= '0;
			active_q    <= 1'b0;
			slot_q      <= '0;
			since_q     <= '0;
		end
		if ((state_q == wzsm_pkg::ST_JOB) && rd_vld_s1 && prog_v_s1 && (sum17[15:0] > len_q)) begin
			len_q <= sum17[15:0];
		end
		if (hit) begin
			active_q <= 1'b1;
			slot_q   <= idx_s1[RAW-1:0];
			since_q  <= diff[15:0];
		end
		if ((state_q == wzsm_pkg::ST_MASK) && rd_vld_s1 && prog_v_s1 &&
			(prog_rd_s1.delay <= since_q) && ({1'b0, since_q} < sum17) &&
			({2'b0, prog_rd_s1.station} < STAT_L)) begin
			mask_q <= mask_q | (STATIONS'(1) << prog_rd_s1.station);
		end
		if (fin_load) begin
			run_active   <= active_q;
			run_slot     <= 3'(slot_q);
			station_mask <= 16'(mask_q);
			job_length   <= len_q;
		end
	end

endmodule

[rtl/wzsm_checker.sv]
`timescale 1ns / 1ps
`include "weekly_zone_schedule_matcher_defines.svh"

module wzsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  mode,
	input logic [2:0]  entry_index,
	input logic        entry_valid,
	input logic [2:0]  run_day,
	input logic [16:0] run_time,
	input logic [1:0]  run_weeks,
	input logic [3:0]  station_number,
	input logic [15:0] start_delay,
	input logic [15:0] open_length,
	input logic [16:0] now_time,
	input logic [2:0]  now_day,
	input logic        week_one,
	input logic        out_valid,
	input logic        out_stall,
	input logic        run_active,
	input logic [2:0]  run_slot,
	input logic [15:0] station_mask,
	input logic [15:0] job_length
);

	`WZSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(station_mask), "stalled transaction dropped or changed")
	`WZSM_ASSERT_IMPL(a_idle_mask, out_valid && !run_active, station_mask == 16'd0 && run_slot == 3'd0, "inactive result carries stations or slot")
	`WZSM_ASSERT_IMPL(a_active_len, out_valid && run_active, job_length != 16'd0, "active run with zero job length")
	`WZSM_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && mode == wzsm_pkg::MODE_QUERY, in_stall, "query transaction did not hold the input")

endmodule

bind weekly_zone_schedule_matcher wzsm_checker u_wzsm_checker (.*);
